>>> hdl/spq_pkg.sv
// spq_pkg: shared types and codes for the sorted priority queue
// depends on nothing; imported by the controller, datapath and top level

package spq_pkg;

    // operation codes of an input item
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_NULL  = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    // field widths
    localparam int ID_W    = 16;
    localparam int TYPE_W  = 16;
    localparam int PRIO_W  = 16;
    localparam int COUNT_W = 7;

    // one stored entry
    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [TYPE_W-1:0] typ;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // take the item and register the per-cell compares
        logic apply;    // commit the operation and load the result register
    } spq_cmd_t;

endpackage

>>> hdl/spq_in_if.sv
// spq_in_if: input channel of the sorted priority queue, valid/ready with payload
// depends on nothing

interface spq_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [15:0]        item_id;
    logic signed [15:0] item_type;
    logic signed [15:0] priority_req;

    modport source (output valid, output op, output item_id, output item_type,
                    output priority_req, input ready);
    modport sink   (input valid, input op, input item_id, input item_type,
                    input priority_req, output ready);
endinterface

>>> hdl/spq_out_if.sv
// spq_out_if: result channel of the sorted priority queue, valid/ready with payload
// depends on nothing

interface spq_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [6:0]         position;
    logic [15:0]        out_id;
    logic signed [15:0] out_type;
    logic signed [15:0] out_priority;
    logic [6:0]         count;

    modport source (output valid, output status, output position, output out_id,
                    output out_type, output out_priority, output count, input ready);
    modport sink   (input valid, input status, input position, input out_id,
                    input out_type, input out_priority, input count, output ready);
endinterface

>>> hdl/spq_ctrl.sv
// spq_ctrl: two-state sequencer of the sorted priority queue
// depends on spq_pkg (command struct)

module spq_ctrl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output spq_cmd_t cmd
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_APPLY = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        in_ready      = (state_reg == S_IDLE);
        cmd.capture   = in_valid && in_ready;
        cmd.apply     = (state_reg == S_APPLY) && (!out_valid_reg || out_ready);
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (cmd.apply)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/spq_cells.sv
// spq_cells: row of sorted entry cells with per-cell compares, fill count and result register
// depends on spq_pkg (entry type, codes, command struct)

module spq_cells
    import spq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  spq_cmd_t                 cmd,
    input  logic                     in_op,
    input  logic [ID_W-1:0]          in_id,
    input  logic signed [TYPE_W-1:0] in_type,
    input  logic signed [PRIO_W-1:0] in_prio,
    output logic [2:0]               res_status,
    output logic [COUNT_W-1:0]       res_position,
    output logic [ID_W-1:0]          res_id,
    output logic signed [TYPE_W-1:0] res_type,
    output logic signed [PRIO_W-1:0] res_prio,
    output logic [COUNT_W-1:0]       res_count
);

    localparam int FILL_W = $clog2(CAPACITY + 1);

    entry_t              cell_reg [CAPACITY];
    entry_t              cell_next [CAPACITY];
    logic [CAPACITY-1:0] le_reg;
    logic [CAPACITY-1:0] match_reg;
    entry_t              req_reg;
    logic                req_op_reg;
    logic [FILL_W-1:0]   fill_reg, fill_next;

    logic                is_null, is_dup, is_full, ins_ok, rem_ok;
    logic [2:0]          status_next;

    // per-cell compares against the incoming item
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic live;
        assign live = (FILL_W'(i) < fill_reg);

        always_ff @(posedge clk)
        begin
            if (cmd.capture)
            begin
                le_reg[i]    <= live && (cell_reg[i].prio <= in_prio);
                match_reg[i] <= live && (cell_reg[i].id == in_id);
            end
        end

        // insert: keep if at or below the new priority, else take the new entry
        // at the boundary, else shift down by one
        entry_t ins_val, rem_val;
        if (i == 0)
        begin : g_head
            assign ins_val = le_reg[0] ? cell_reg[0] : req_reg;
        end
        else
        begin : g_body
            assign ins_val = le_reg[i]   ? cell_reg[i] :
                             le_reg[i-1] ? req_reg     : cell_reg[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_tail
            assign rem_val = cell_reg[i];
        end
        else
        begin : g_mid
            assign rem_val = cell_reg[i+1];
        end

        always_comb
        begin
            priority if (ins_ok)
            begin
                cell_next[i] = ins_val;
            end
            else if (rem_ok)
            begin
                cell_next[i] = rem_val;
            end
            else
            begin
                cell_next[i] = cell_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            cell_reg <= cell_next;
        end
    end

    // request register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_op_reg   <= in_op;
            req_reg.id   <= in_id;
            req_reg.typ  <= in_type;
            req_reg.prio <= in_prio;
        end
    end

    // checks in order: null, duplicate, full
    always_comb
    begin
        is_null = (req_reg.id == '0);
        is_dup  = |match_reg;
        is_full = (fill_reg == FILL_W'(CAPACITY));
        ins_ok  = cmd.apply && (req_op_reg == OP_INSERT) && !is_null && !is_dup && !is_full;
        rem_ok  = cmd.apply && (req_op_reg == OP_REMOVE) && (fill_reg != '0);

        fill_next = fill_reg;
        if (ins_ok)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (rem_ok)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end

        if (req_op_reg == OP_INSERT)
        begin
            priority if (is_null)
            begin
                status_next = ST_NULL;
            end
            else if (is_dup)
            begin
                status_next = ST_DUP;
            end
            else if (is_full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_OK;
            end
        end
        else
        begin
            status_next = (fill_reg == '0) ? ST_EMPTY : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.apply)
        begin
            fill_reg <= fill_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            res_status   <= status_next;
            res_position <= ins_ok ? COUNT_W'(fill_reg) : '0;
            res_id       <= rem_ok ? cell_reg[0].id   : '0;
            res_type     <= rem_ok ? cell_reg[0].typ  : '0;
            res_prio     <= rem_ok ? cell_reg[0].prio : '0;
            res_count    <= COUNT_W'(fill_next);
        end
    end

endmodule

>>> hdl/sorted_priority_queue.sv
// sorted_priority_queue: top level, joins the sequencer and the cell datapath to the channels
// depends on spq_pkg, spq_in_if, spq_out_if, spq_ctrl, spq_cells
//
// Priority queue of up to CAPACITY entries (identifier, type, priority) kept in
// ascending priority order in a row of registered cells, equal priorities in
// arrival order. An insert item (op 0) is rejected with status null when its
// identifier is 0, duplicate when the identifier is already held, full when
// the queue holds CAPACITY entries, checked in that order; a successful insert
// returns the count before it in position. A remove item (op 1) returns the
// head entry, or status empty when there is none. Each item gives exactly one
// result, carrying the count after the step (low 7 bits). The edge that accepts
// an item registers the priority and identifier compares of every cell; a later
// edge commits the shift of the cell row and loads the result register once the
// result slot is free, and no new item is taken before that commit. One item is
// in flight at a time; a result waiting in the output register holds the commit
// of the following item until taken. No clearing pass is needed after reset:
// only cells below the fill count are ever looked at.

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input logic        clk,
    input logic        rst_n,
    spq_in_if.sink     in_ch,
    spq_out_if.source  out_ch
);

    spq_cmd_t cmd;

    // sequencer: accepts an item when idle, commits it when the result slot is free
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // cell row, fill count and result register
    spq_cells #(
        .CAPACITY (CAPACITY)
    ) u_cells (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_op        (in_ch.op),
        .in_id        (in_ch.item_id),
        .in_type      (in_ch.item_type),
        .in_prio      (in_ch.priority_req),
        .res_status   (out_ch.status),
        .res_position (out_ch.position),
        .res_id       (out_ch.out_id),
        .res_type     (out_ch.out_type),
        .res_prio     (out_ch.out_priority),
        .res_count    (out_ch.count)
    );

endmodule

>>> dv/testbench.sv
// testbench: self-checking bench for the sorted priority queue, single file
// depends on spq_pkg, spq_in_if, spq_out_if and the sorted_priority_queue top level
// an in-bench queue model predicts every result; a checker compares them field by field

module testbench;
    import spq_pkg::*;

    localparam int CAPACITY = 64;
    localparam int IDLE_PCT = 17;       // chance in a hundred of an idle cycle on either side
    localparam int DRAIN_LIMIT = 20000; // cycles allowed for outstanding results to arrive

    // one expected result, laid out as the result channel carries it
    typedef struct packed {
        logic [2:0]         status;
        logic [6:0]         position;
        logic [15:0]        id;
        logic signed [15:0] typ;
        logic signed [15:0] prio;
        logic [6:0]         count;
    } result_t;

    logic clk;
    logic rst_n;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    sorted_priority_queue #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // queue model: held entries in service order, head first
    entry_t  held_entries[$];
    // results predicted at acceptance, oldest first
    result_t pending_results[$];

    bit stalls_on = 1'b1;   // cleared for the stretch with no idling on either side

    int mismatches;
    int items_sent;
    int results_checked;
    int inserts_done;
    int removes_done;
    int null_rejects;
    int dup_rejects;
    int full_rejects;
    int empty_removes;
    int deepest_fill;

    // ---------------------------------------------------------------
    // clock and timeout
    // ---------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous upper bound, well beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("timeout after %0d items sent, %0d results checked", items_sent,
                 results_checked);
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------
    // queue model
    // ---------------------------------------------------------------

    // applies one accepted item to the held entries and returns its result
    function automatic result_t queue_step(input logic op, input logic [15:0] id,
                                           input logic signed [15:0] typ,
                                           input logic signed [15:0] prio);
        result_t r;
        entry_t  e;
        int      slot;
        bit      already_held;

        r = '0;
        if (op == OP_INSERT)
        begin
            already_held = 1'b0;
            foreach (held_entries[i])
                if (held_entries[i].id == id)
                    already_held = 1'b1;
            // checks run null, then duplicate, then full
            if (id == '0)
            begin
                r.status = ST_NULL;
                null_rejects++;
            end
            else if (already_held)
            begin
                r.status = ST_DUP;
                dup_rejects++;
            end
            else if (held_entries.size() >= CAPACITY)
            begin
                r.status = ST_FULL;
                full_rejects++;
            end
            else
            begin
                // new entry goes behind every entry of lower or equal priority
                slot = 0;
                while (slot < held_entries.size() && held_entries[slot].prio <= prio)
                    slot++;
                e.id   = id;
                e.typ  = typ;
                e.prio = prio;
                r.status   = ST_OK;
                r.position = 7'(held_entries.size());
                held_entries.insert(slot, e);
                inserts_done++;
            end
        end
        else
        begin
            if (held_entries.size() == 0)
            begin
                r.status = ST_EMPTY;
                empty_removes++;
            end
            else
            begin
                e = held_entries.pop_front();
                r.status = ST_OK;
                r.id     = e.id;
                r.typ    = e.typ;
                r.prio   = e.prio;
                removes_done++;
            end
        end
        r.count = 7'(held_entries.size());
        if (held_entries.size() > deepest_fill)
            deepest_fill = held_entries.size();
        return r;
    endfunction

    // ---------------------------------------------------------------
    // reporting and result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int wanted);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, wanted);
        mismatches++;
    endtask

    // result side stalls at random while stalls are on
    always @(negedge clk)
    begin
        out_ch.ready = !(stalls_on && $urandom_range(99) < IDLE_PCT);
    end

    // every accepted result is matched against the oldest prediction
    always @(posedge clk)
    begin
        result_t wanted;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected, status", out_ch.status, 0);
            else
            begin
                wanted = pending_results.pop_front();
                results_checked++;
                if (out_ch.status !== wanted.status)
                    report_mismatch("status mismatch", out_ch.status, wanted.status);
                if (out_ch.position !== wanted.position)
                    report_mismatch("position mismatch", out_ch.position, wanted.position);
                if (out_ch.out_id !== wanted.id)
                    report_mismatch("out_id mismatch", out_ch.out_id, wanted.id);
                if (out_ch.out_type !== wanted.typ)
                    report_mismatch("out_type mismatch", int'(out_ch.out_type),
                                    int'(wanted.typ));
                if (out_ch.out_priority !== wanted.prio)
                    report_mismatch("out_priority mismatch", int'(out_ch.out_priority),
                                    int'(wanted.prio));
                if (out_ch.count !== wanted.count)
                    report_mismatch("count mismatch", out_ch.count, wanted.count);
            end
        end
    end

    // ---------------------------------------------------------------
    // item driving
    // ---------------------------------------------------------------

    // drives one item from a falling edge, holds it until taken, then predicts its result
    task automatic send_item(input logic op, input logic [15:0] id,
                             input logic signed [15:0] typ, input logic signed [15:0] prio);
        @(negedge clk);
        while (stalls_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.op           = op;
        in_ch.item_id      = id;
        in_ch.item_type    = typ;
        in_ch.priority_req = prio;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_results.push_back(queue_step(op, id, typ, prio));
        items_sent++;
    endtask

    // random item; ids mostly from a small pool so duplicates are common,
    // priorities often from a narrow band so ties are common
    task automatic send_random(input int insert_pct);
        logic               op;
        logic [15:0]        id;
        logic signed [15:0] prio;
        int                 pick;

        op   = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        pick = $urandom_range(99);
        if (pick < 5)
            id = '0;
        else if (pick < 65)
            id = 16'($urandom_range(1, 200));
        else
            id = 16'($urandom);
        if ($urandom_range(1) == 0)
            prio = 16'(int'($urandom_range(7)) - 4);
        else
            prio = 16'($urandom);
        send_item(op, id, 16'($urandom), prio);
    endtask

    // sender stops and waits until every predicted result has been taken
    task automatic wait_for_results();
        int guard;

        guard = 0;
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        // an extra wait in case anything stray is still on its way
        repeat (6) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // field extremes, every status but full, ties kept in arrival order
    task automatic test_edge_cases();
        send_item(OP_REMOVE, 16'h0000, 16'sh0000, 16'sh0000);    // remove from empty queue
        send_item(OP_INSERT, 16'h0000, -16'sd1, 16'sh0000);      // null item
        send_item(OP_INSERT, 16'hFFFF, 16'sh8000, 16'sh7FFF);    // largest id, lowest priority
        send_item(OP_INSERT, 16'h0001, 16'sh7FFF, 16'sh8000);    // goes straight to the head
        send_item(OP_INSERT, 16'h8000, 16'sh0000, 16'sh0000);
        send_item(OP_INSERT, 16'h7FFF, -16'sd1, 16'sh0000);      // tie, goes behind
        send_item(OP_INSERT, 16'h0002, 16'sh5555, 16'sh0000);    // third of the tie
        send_item(OP_INSERT, 16'h0001, 16'shAAAA, 16'sh0000);    // duplicate at the head
        send_item(OP_INSERT, 16'hFFFF, 16'sh0000, 16'sh8000);    // duplicate at the tail
        send_item(OP_INSERT, 16'h0000, 16'sh7FFF, 16'sh7FFF);    // null wins over anything
        send_item(OP_INSERT, 16'h0003, 16'sh1234, -16'sd1);
        send_item(OP_INSERT, 16'h0004, 16'shFFFF, 16'sh7FFF);    // tie at the tail
        repeat (8)
            send_item(OP_REMOVE, 16'($urandom), 16'($urandom), 16'($urandom));
        wait_for_results();
    endtask

    // fill to capacity, hit every rejection there, then drain past empty
    task automatic test_fill_to_capacity();
        int n;

        n = 0;
        while (held_entries.size() < CAPACITY)
        begin
            send_item(OP_INSERT, 16'(1000 + n), 16'($urandom),
                      16'(int'($urandom_range(7)) - 4));
            n++;
        end
        send_item(OP_INSERT, 16'h0000, 16'sh0000, 16'sh0000);            // null on full
        send_item(OP_INSERT, held_entries[5].id, 16'sh0000, 16'sh0000);  // duplicate on full
        send_item(OP_INSERT, 16'd5000, 16'sh0101, 16'sh0000);            // full
        send_item(OP_REMOVE, 16'h0000, 16'sh0000, 16'sh0000);
        send_item(OP_INSERT, 16'd5000, 16'sh0101, 16'sh7FFF);            // last free slot
        send_item(OP_INSERT, 16'd5001, 16'sh0202, 16'sh8000);            // full again
        while (held_entries.size() > 0)
            send_item(OP_REMOVE, 16'($urandom), 16'($urandom), 16'($urandom));
        send_item(OP_REMOVE, 16'h0000, 16'sh0000, 16'sh0000);
        wait_for_results();
    endtask

    // mixed traffic whose insert bias swings so the fill sweeps up and down
    task automatic test_random_traffic();
        int bias[4] = '{85, 50, 15, 65};
        int insert_pct;

        insert_pct = 50;
        for (int i = 0; i < 400; i++)
        begin
            if (i % 50 == 0)
                insert_pct = bias[$urandom_range(3)];
            // one pause mid-run with the sender waiting on every result
            if (i == 200)
                wait_for_results();
            send_random(insert_pct);
        end
        wait_for_results();
    endtask

    // back-to-back items with the result side always ready
    task automatic test_unstalled_burst();
        stalls_on = 1'b0;
        for (int i = 0; i < 100; i++)
            send_random((i < 60) ? 70 : 30);
        wait_for_results();
        stalls_on = 1'b1;
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.op           = OP_INSERT;
        in_ch.item_id      = '0;
        in_ch.item_type    = '0;
        in_ch.priority_req = '0;
        out_ch.ready       = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_edge_cases();
        test_fill_to_capacity();
        test_random_traffic();
        test_unstalled_burst();

        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());

        $display("%0d items sent and %0d results checked, deepest fill %0d of %0d",
                 items_sent, results_checked, deepest_fill, CAPACITY);
        $display("%0d inserts, %0d removes, %0d null, %0d duplicate, %0d full, %0d empty",
                 inserts_done, removes_done, null_rejects, dup_rejects, full_rejects,
                 empty_removes);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
